FILE: hdl/median_filter_4x4_unit_defines.svh
// Assertion macros shared by the median filter RTL.
`ifndef MEDIAN_FILTER_4X4_UNIT_DEFINES_SVH
`define MEDIAN_FILTER_4X4_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MEDF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MEDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/medf_pkg.sv
// Shared types and constants of the median filter.
package medf_pkg;

  localparam int PIX_W = 8;
  localparam int DIM_W = 12;
  localparam int CFG_IDX_W = 1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 12'd256;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 12'd720;

  // Per-word control decided at accept time.
  typedef struct packed {
    logic is_pix;
    logic emit;
    logic interior;
    logic last;
  } medf_ctl_t;

endpackage

FILE: hdl/medf_ram.sv
// Generic single-write, single-read RAM with registered read (read-first).
module medf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/medf_seq.sv
// Stream sequencer: config registers, raster counters and output decision.
module medf_seq #(
  parameter int MAX_WIDTH = 2048,
  parameter int KSIZE     = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            acc_i,
  input  logic                            cmd_i,
  input  logic                            cfg_we_i,
  input  logic [medf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [medf_pkg::DIM_W-1:0]      cfg_data_i,
  output medf_pkg::medf_ctl_t             ctl_o,
  output logic [((KSIZE>2)?$clog2(KSIZE-1):1)-1:0] wr_slot_o,
  output logic [$clog2(MAX_WIDTH)-1:0]    wr_col_o,
  output logic [((KSIZE>2)?$clog2(KSIZE-1):1)-1:0] pt_slot_o,
  output logic [$clog2(MAX_WIDTH)-1:0]    pt_col_o,
  output logic                            busy_o
);

  localparam int NROWS = KSIZE - 1;
  localparam int DLY   = KSIZE - 2;
  localparam int SW    = (NROWS > 1) ? $clog2(NROWS) : 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int DW    = medf_pkg::DIM_W;
  localparam int EW    = DW + 2;
  localparam int MIN_DIM = ((KSIZE + 2) > 6) ? (KSIZE + 2) : 6;
  localparam int PW    = $clog2(DLY * MAX_WIDTH + KSIZE + 1) + 1;
  localparam int OW    = DW + CW;   // linear output index
  localparam int XW    = OW + 1;
  localparam int RW    = DW + 2;    // divider remainder
  localparam int NW    = $clog2(OW + 1);

  logic [DW-1:0] fw_q, fh_q, row_q, row_d;
  logic [OW-1:0] orow_q, orow_d, oidx_q, oidx_d;
  logic [CW-1:0] col_q, col_d, ocol_q, ocol_d;
  logic [SW-1:0] slot_q, slot_d, oslot_q, oslot_d;
  logic [PW-1:0] pend_q, pend_d;

  logic [DW-1:0] w_c, h_c;
  logic [OW-1:0] orow_b, oidx_b;
  logic [CW-1:0] ocol_b;
  logic [SW-1:0] oslot_b;
  logic [PW-1:0] pend_b, dly_c;
  logic          fs, is_pix, emit, last, interior;

  // width change: re-derive output row/col/slot from the linear index
  logic          busy_q, busy_d, wr_w, div_done;
  logic [OW-1:0] dq_q, dq_d;
  logic [RW-1:0] rem_q, rem_d, rem_t;
  logic [SW-1:0] m_q, m_d;
  logic [SW:0]   m_t;
  logic [NW-1:0] cnt_q, cnt_d;

  always_comb begin
    if (fw_q < DW'(MIN_DIM)) begin
      w_c = DW'(MIN_DIM);
    end else if (EW'(fw_q) > EW'(MAX_WIDTH)) begin
      w_c = DW'(MAX_WIDTH);
    end else begin
      w_c = fw_q;
    end
    h_c = (fh_q < DW'(MIN_DIM)) ? DW'(MIN_DIM) : fh_q;
    dly_c = PW'(PW'(DLY) * PW'(w_c)) + PW'(DLY);

    fs     = (row_q == '0) && (col_q == '0);
    is_pix = (cmd_i == medf_pkg::CMD_PIXEL);

    // a source word at frame start drops whatever the last frame left
    if (is_pix && fs) begin
      pend_b  = '0;
      orow_b  = '0;
      ocol_b  = '0;
      oslot_b = '0;
      oidx_b  = '0;
    end else begin
      pend_b  = pend_q;
      orow_b  = orow_q;
      ocol_b  = ocol_q;
      oslot_b = oslot_q;
      oidx_b  = oidx_q;
    end

    emit = is_pix ? (pend_b >= dly_c) : (fs && (pend_q != '0));

    interior = (orow_b != '0) && (XW'(orow_b) + XW'(KSIZE) < XW'(h_c)) &&
               (ocol_b != '0) && (EW'(ocol_b) + EW'(KSIZE) < EW'(w_c));
    // row can sit past the frame after a size change
    last = (XW'(orow_b) >= XW'(h_c)) ||
           ((XW'(orow_b) + XW'(1) == XW'(h_c)) && (EW'(ocol_b) + EW'(1) >= EW'(w_c)));

    // input raster
    row_d  = row_q;
    col_d  = col_q;
    slot_d = slot_q;
    if (is_pix) begin
      if (EW'(col_q) + EW'(1) >= EW'(w_c)) begin
        col_d = '0;
        if (EW'(row_q) + EW'(1) >= EW'(h_c)) begin
          row_d  = '0;
          slot_d = '0;
        end else begin
          row_d  = row_q + DW'(1);
          slot_d = (slot_q == SW'(NROWS - 1)) ? '0 : slot_q + SW'(1);
        end
      end else begin
        col_d = col_q + CW'(1);
      end
    end

    // output raster
    orow_d  = orow_b;
    ocol_d  = ocol_b;
    oslot_d = oslot_b;
    oidx_d  = oidx_b;
    if (emit) begin
      if (last) begin
        orow_d  = '0;
        ocol_d  = '0;
        oslot_d = '0;
        oidx_d  = '0;
      end else if (EW'(ocol_b) + EW'(1) >= EW'(w_c)) begin
        ocol_d  = '0;
        orow_d  = orow_b + OW'(1);
        oslot_d = (oslot_b == SW'(NROWS - 1)) ? '0 : oslot_b + SW'(1);
        oidx_d  = oidx_b + OW'(1);
      end else begin
        ocol_d = ocol_b + CW'(1);
        oidx_d = oidx_b + OW'(1);
      end
    end

    if (is_pix) begin
      pend_d = emit ? pend_b : pend_b + PW'(1);
    end else begin
      pend_d = emit ? pend_q - PW'(1) : pend_q;
    end
  end

  // restoring divider, one quotient bit per cycle; quotient mod NROWS on the fly
  always_comb begin
    wr_w   = cfg_we_i && (cfg_idx_i == medf_pkg::REG_WIDTH);
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    m_d    = m_q;
    rem_t  = '0;
    m_t    = '0;
    if (wr_w) begin
      busy_d = 1'b1;
      cnt_d  = NW'(OW);
      dq_d   = acc_i ? oidx_d : oidx_q;
      rem_d  = '0;
      m_d    = '0;
    end else if (busy_q) begin
      rem_t = {rem_q[RW-2:0], dq_q[OW-1]};
      dq_d  = {dq_q[OW-2:0], 1'b0};
      if (rem_t >= RW'(w_c)) begin
        rem_t   = rem_t - RW'(w_c);
        dq_d[0] = 1'b1;
      end
      m_t = {m_q, dq_d[0]};
      if (m_t >= (SW+1)'(NROWS)) begin
        m_t = m_t - (SW+1)'(NROWS);
      end
      rem_d = rem_t;
      m_d   = m_t[SW-1:0];
      cnt_d = cnt_q - NW'(1);
      if (cnt_q == NW'(1)) begin
        busy_d = 1'b0;
      end
    end
    div_done = busy_q && !wr_w && (cnt_q == NW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q    <= medf_pkg::WIDTH_RST;
      fh_q    <= medf_pkg::HEIGHT_RST;
      row_q   <= '0;
      col_q   <= '0;
      slot_q  <= '0;
      orow_q  <= '0;
      ocol_q  <= '0;
      oslot_q <= '0;
      oidx_q  <= '0;
      pend_q  <= '0;
      busy_q  <= 1'b0;
      cnt_q   <= '0;
      dq_q    <= '0;
      rem_q   <= '0;
      m_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          medf_pkg::REG_WIDTH:  fw_q <= cfg_data_i;
          medf_pkg::REG_HEIGHT: fh_q <= cfg_data_i;
          default: ;
        endcase
      end
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      dq_q   <= dq_d;
      rem_q  <= rem_d;
      m_q    <= m_d;
      if (acc_i) begin
        row_q   <= row_d;
        col_q   <= col_d;
        slot_q  <= slot_d;
        orow_q  <= orow_d;
        ocol_q  <= ocol_d;
        oslot_q <= oslot_d;
        oidx_q  <= oidx_d;
        pend_q  <= pend_d;
      end else if (div_done) begin
        orow_q  <= dq_d;
        ocol_q  <= rem_d[CW-1:0];
        oslot_q <= m_d;
      end
    end
  end

  assign ctl_o.is_pix   = is_pix;
  assign ctl_o.emit     = emit;
  assign ctl_o.interior = interior;
  assign ctl_o.last     = last;
  assign wr_slot_o      = slot_q;
  assign wr_col_o       = col_q;
  assign pt_slot_o      = oslot_b;
  assign pt_col_o       = ocol_b;
  assign busy_o         = busy_q;

endmodule

FILE: hdl/medf_rank.sv
// Pairwise order matrix of the window: bit [i][j] set when j sorts ahead of i.
module medf_rank #(
  parameter int N = 16
) (
  input  logic [N-1:0][medf_pkg::PIX_W-1:0] vals_i,
  output logic [N-1:0][N-1:0]               ahead_o
);

  always_comb begin
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        ahead_o[i][j] = (j != i) &&
                        ((vals_i[j] < vals_i[i]) || ((vals_i[j] == vals_i[i]) && (j < i)));
      end
    end
  end

endmodule

FILE: hdl/medf_pick.sv
// Picks the window element whose sorted position equals SEL.
module medf_pick #(
  parameter int N   = 16,
  parameter int SEL = 8
) (
  input  logic [N-1:0][N-1:0]               ahead_i,
  input  logic [N-1:0][medf_pkg::PIX_W-1:0] vals_i,
  output logic [medf_pkg::PIX_W-1:0]        med_o
);

  localparam int RW = $clog2(N + 1);

  logic [RW-1:0] rank [N];

  always_comb begin
    med_o = '0;
    for (int i = 0; i < N; i++) begin
      rank[i] = '0;
      for (int j = 0; j < N; j++) begin
        rank[i] = rank[i] + RW'(ahead_i[i][j]);
      end
      if (rank[i] == RW'(SEL)) begin
        med_o = med_o | vals_i[i];
      end
    end
  end

endmodule

FILE: hdl/median_filter_4x4_unit.sv
// Top level of the streaming 4x4 upper-median filter.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in      | sink      | in_valid_i/in_stall_o | cmd_i, pixel_in_i
//  out     | source    | out_valid_o/out_stall_i| pixel_out_o, frame_last_o
//  cfg     | sink      | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// One word per cycle sustained while in_stall_o is low; each memory has
// one write and one read port and is touched once per word.
// Reset clears counters, window and pipeline; line memories are not cleared.
// out_stall_i backs up through the stages; in_stall_o rises when the
// first stage holds a word that cannot move on, and after a width write
// while the output row/col is re-derived from the linear index.
`include "median_filter_4x4_unit_defines.svh"

module median_filter_4x4_unit #(
  parameter int MAX_WIDTH = 2048,
  parameter int KSIZE     = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           cmd_i,
  input  logic [medf_pkg::PIX_W-1:0]     pixel_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [medf_pkg::PIX_W-1:0]     pixel_out_o,
  output logic                           frame_last_o,
  input  logic                           cfg_we_i,
  input  logic [medf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [medf_pkg::DIM_W-1:0]     cfg_data_i
);

  localparam int N     = KSIZE * KSIZE;
  localparam int NROWS = KSIZE - 1;
  localparam int SW    = (NROWS > 1) ? $clog2(NROWS) : 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int CAW   = SW + CW;
  localparam int PXW   = medf_pkg::PIX_W;

  // stage 0: accept, memory access, raster bookkeeping
  logic                acc;
  logic                seq_busy;
  medf_pkg::medf_ctl_t ctl0;
  logic [SW-1:0]       wr_slot, pt_slot;
  logic [CW-1:0]       wr_col, pt_col;
  logic [NROWS-1:0]    line_we;
  logic [PXW-1:0]      line_rd [NROWS];
  logic [PXW-1:0]      copy_rd;
  logic                copy_we;
  logic                fwd0;

  // handshake chain
  logic rdy1, rdy2, rdy3, rdy_o, go1, go2, go3;

  // stage 1: window update
  logic                v1_q;
  medf_pkg::medf_ctl_t ctl1_q;
  logic [SW-1:0]       slot1_q;
  logic [PXW-1:0]      px1_q;
  logic                fwd1_q;
  logic [N-1:0][PXW-1:0] win_q, win_d;

  // stage 2: order matrix
  logic           v2_q, int2_q, last2_q;
  logic [PXW-1:0] pass2_q;
  logic [N-1:0][N-1:0] ahead;

  // stage 3: rank select
  logic                  v3_q, int3_q, last3_q;
  logic [PXW-1:0]        pass3_q;
  logic [N-1:0][N-1:0]   ahead3_q;
  logic [N-1:0][PXW-1:0] vals3_q;
  logic [PXW-1:0]        med;

  // output register
  logic           out_v_q, last_o_q;
  logic [PXW-1:0] pix_o_q;

  assign rdy_o = !out_v_q || !out_stall_i;
  assign rdy3  = !v3_q || rdy_o;
  assign rdy2  = !v2_q || rdy3;
  assign rdy1  = !v1_q || rdy2;
  assign go1   = v1_q && rdy2;
  assign go2   = v2_q && rdy3;
  assign go3   = v3_q && rdy_o;

  assign in_stall_o = !rdy1 || seq_busy;
  assign acc        = in_valid_i && rdy1 && !seq_busy;

  medf_seq #(
    .MAX_WIDTH(MAX_WIDTH),
    .KSIZE    (KSIZE)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .cmd_i     (cmd_i),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .ctl_o     (ctl0),
    .wr_slot_o (wr_slot),
    .wr_col_o  (wr_col),
    .pt_slot_o (pt_slot),
    .pt_col_o  (pt_col),
    .busy_o    (seq_busy)
  );

  // one line memory per buffered row; read-first gives the row three back
  for (genvar s = 0; s < NROWS; s++) begin : g_line
    assign line_we[s] = acc && ctl0.is_pix && (wr_slot == SW'(s));
    medf_ram #(
      .WIDTH(PXW),
      .DEPTH(MAX_WIDTH)
    ) u_line (
      .clk_i  (clk_i),
      .we_i   (line_we[s]),
      .waddr_i(wr_col),
      .wdata_i(pixel_in_i),
      .re_i   (acc),
      .raddr_i(wr_col),
      .rdata_o(line_rd[s])
    );
  end

  // shadow of all line rows, read at the output position for pass-through
  assign copy_we = acc && ctl0.is_pix;
  assign fwd0    = copy_we && (pt_slot == wr_slot) && (pt_col == wr_col);

  medf_ram #(
    .WIDTH(PXW),
    .DEPTH(2 ** CAW)
  ) u_copy (
    .clk_i  (clk_i),
    .we_i   (copy_we),
    .waddr_i({wr_slot, wr_col}),
    .wdata_i(pixel_in_i),
    .re_i   (acc),
    .raddr_i({pt_slot, pt_col}),
    .rdata_o(copy_rd)
  );

  // shift window left, new right column from the rows in age order
  always_comb begin
    logic [SW:0] sum;
    win_d = win_q;
    for (int a = 0; a < KSIZE; a++) begin
      for (int b = 0; b < KSIZE - 1; b++) begin
        win_d[a*KSIZE+b] = win_q[a*KSIZE+b+1];
      end
      if (a < KSIZE - 1) begin
        sum = {1'b0, slot1_q} + (SW+1)'(a);
        if (sum >= (SW+1)'(NROWS)) begin
          sum = sum - (SW+1)'(NROWS);
        end
        win_d[a*KSIZE+KSIZE-1] = '0;
        for (int s = 0; s < NROWS; s++) begin
          if (sum == (SW+1)'(s)) begin
            win_d[a*KSIZE+KSIZE-1] = line_rd[s];
          end
        end
      end else begin
        win_d[a*KSIZE+KSIZE-1] = px1_q;
      end
    end
  end

  medf_rank #(
    .N(N)
  ) u_rank (
    .vals_i (win_q),
    .ahead_o(ahead)
  );

  medf_pick #(
    .N  (N),
    .SEL(N / 2)
  ) u_pick (
    .ahead_i(ahead3_q),
    .vals_i (vals3_q),
    .med_o  (med)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
      win_q   <= '0;
    end else begin
      if (rdy1) begin
        v1_q <= acc;
      end
      if (rdy2) begin
        v2_q <= v1_q && ctl1_q.emit;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy_o) begin
        out_v_q <= v3_q;
      end
      // window moves only when a pixel word leaves stage 1
      if (go1 && ctl1_q.is_pix) begin
        win_q <= win_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (acc) begin
      ctl1_q  <= ctl0;
      slot1_q <= wr_slot;
      px1_q   <= pixel_in_i;
      fwd1_q  <= fwd0;
    end
    if (go1) begin
      int2_q  <= ctl1_q.interior;
      last2_q <= ctl1_q.last;
      pass2_q <= fwd1_q ? px1_q : copy_rd;
    end
    if (go2) begin
      int3_q   <= int2_q;
      last3_q  <= last2_q;
      pass3_q  <= pass2_q;
      ahead3_q <= ahead;
      vals3_q  <= win_q;
    end
    if (go3) begin
      pix_o_q  <= int3_q ? med : pass3_q;
      last_o_q <= last3_q;
    end
  end

  assign out_valid_o  = out_v_q;
  assign pixel_out_o  = pix_o_q;
  assign frame_last_o = last_o_q;

  `MEDF_ASSERT_NOW(a_one_line_write, 1'b1, $onehot0(line_we), "two line rows written at once")
  `MEDF_ASSERT_NOW(a_empty_takes, !v1_q && !seq_busy, !in_stall_o, "stall with empty first stage")
  `MEDF_ASSERT_NOW(a_flush_no_write, acc && (cmd_i == medf_pkg::CMD_FLUSH), !copy_we, "flush wrote memory")
  `MEDF_ASSERT_NEXT(a_hold_s2, v2_q && !rdy3, v2_q && $stable(pass2_q), "stage 2 word lost")

endmodule

FILE: sim/median_filter_4x4_unit_tb.sv
// Self-checking testbench for the streaming 4x4 upper-median filter.
`timescale 1ns / 1ps

module median_filter_4x4_unit_tb;

  localparam int LINE_CAP   = 2048;
  localparam int MIN_DIM    = 6;
  localparam int MAX_HGT    = 4095;
  localparam int TAIL_WAIT  = 12;
  localparam int HOLD_LEN   = 300;
  localparam int CYCLE_CAP  = 4000000;
  localparam int RAND_WORDS = 400;

  typedef struct packed {
    logic [medf_pkg::PIX_W-1:0] pix;
    logic                       last;
  } result_t;

  // Tracks the filter's state, predicts each output word and checks it.
  class median_tracker;
    logic [medf_pkg::PIX_W-1:0] rows [3*LINE_CAP];
    logic [medf_pkg::PIX_W-1:0] win [4][4];
    int unsigned                in_row, in_col, out_idx, pend;
    logic [medf_pkg::DIM_W-1:0] reg_w, reg_h;
    result_t                    due [$];
    int                         errors;

    function new();
      foreach (rows[i]) rows[i] = '0;
      foreach (win[a, b]) win[a][b] = '0;
      in_row = 0; in_col = 0; out_idx = 0; pend = 0;
      reg_w = medf_pkg::WIDTH_RST; reg_h = medf_pkg::HEIGHT_RST;
      errors = 0;
    endfunction

    function void set_reg(logic [medf_pkg::CFG_IDX_W-1:0] idx,
                          logic [medf_pkg::DIM_W-1:0] val);
      if (idx == medf_pkg::REG_WIDTH) reg_w = val;
      else reg_h = val;
    endfunction

    function int unsigned eff_w();
      return reg_w < MIN_DIM ? MIN_DIM : (reg_w > LINE_CAP ? LINE_CAP : reg_w);
    endfunction

    function int unsigned eff_h();
      return reg_h < MIN_DIM ? MIN_DIM : (reg_h > MAX_HGT ? MAX_HGT : reg_h);
    endfunction

    // Upper median: smallest value with at least nine entries at or below it.
    function logic [medf_pkg::PIX_W-1:0] upper_median();
      int cnt;
      for (int v = 0; v < 256; v++) begin
        cnt = 0;
        foreach (win[a, b]) if (win[a][b] <= v) cnt++;
        if (cnt >= 9) return v[medf_pkg::PIX_W-1:0];
      end
      return '1;
    endfunction

    function void push_output(int unsigned w, int unsigned h);
      int unsigned oi, oj;
      result_t r;
      oi = out_idx / w;
      oj = out_idx % w;
      if (oi >= 1 && oi + 4 < h && oj >= 1 && oj + 4 < w) r.pix = upper_median();
      else r.pix = rows[(oi % 3) * LINE_CAP + (oj % LINE_CAP)];
      r.last = (out_idx + 1 >= w * h);
      due = {due, r};
      out_idx++;
      if (out_idx >= w * h) out_idx = 0;
      pend--;
    endfunction

    // Called for every accepted input word.
    function void note_word(logic cmd, logic [medf_pkg::PIX_W-1:0] px);
      int unsigned w, h, c;
      w = eff_w();
      h = eff_h();
      if (cmd == medf_pkg::CMD_FLUSH) begin
        if (in_row == 0 && in_col == 0 && pend > 0) push_output(w, h);
        return;
      end
      if (in_row == 0 && in_col == 0) begin
        pend = 0;
        out_idx = 0;
      end
      c = in_col % LINE_CAP;
      for (int a = 0; a < 4; a++) begin
        for (int b = 0; b < 3; b++) win[a][b] = win[a][b+1];
        if (a < 3) win[a][3] = rows[((in_row + a) % 3) * LINE_CAP + c];
        else win[a][3] = px;
      end
      rows[(in_row % 3) * LINE_CAP + c] = px;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) in_row = 0;
      end
      pend++;
      if (pend > 2 * w + 2) push_output(w, h);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic [medf_pkg::PIX_W-1:0] pix, logic last);
      result_t e;
      if (due.size() == 0) begin
        report($sformatf("unexpected word pix=%0d last=%0b", pix, last));
        return;
      end
      e = due.pop_front();
      if (pix !== e.pix) report($sformatf("pixel_out %0d, want %0d", pix, e.pix));
      if (last !== e.last) report($sformatf("frame_last %0b, want %0b", last, e.last));
    endtask
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic                           cmd_i = medf_pkg::CMD_PIXEL;
  logic [medf_pkg::PIX_W-1:0]     pixel_in_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [medf_pkg::PIX_W-1:0]     pixel_out_o;
  logic                           frame_last_o;
  logic                           cfg_we_i = 1'b0;
  logic [medf_pkg::CFG_IDX_W-1:0] cfg_idx_i = medf_pkg::REG_WIDTH;
  logic [medf_pkg::DIM_W-1:0]     cfg_data_i = '0;

  median_filter_4x4_unit u_top (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .cmd_i, .pixel_in_i,
    .out_valid_o, .out_stall_i, .pixel_out_o, .frame_last_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  median_tracker tracker = new();

  bit          idle_en = 1'b0;   // random gaps on both sides
  bit          hold_req = 1'b0;  // ask the receiver for one long stall
  int          pix_mode = 0;     // content style of random pixels
  int unsigned words_sent = 0;
  longint      cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop if the run hangs.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: draws a stall length per word; honors a long hold-off on request.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        for (int n = 0; n < HOLD_LEN; n++) @(negedge clk_i);
        hold_req = 1'b0;
      end
      gap = idle_en ? int'($urandom_range(0, 19)) : 0;
      if (gap > 0) begin
        out_stall_i = 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      tracker.check_result(pixel_out_o, frame_last_o);
    end
  end

  // Offer one word; returns after it is accepted, at the next falling edge.
  task send_word(logic cmd, logic [medf_pkg::PIX_W-1:0] px);
    int gap;
    gap = idle_en ? int'($urandom_range(0, 19)) : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    cmd_i = cmd;
    pixel_in_i = px;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_word(cmd, px);
    words_sent++;
    @(negedge clk_i);
  endtask

  // Pause the sender until every predicted word has come out.
  task settle();
    in_valid_i = 1'b0;
    while (tracker.due.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task write_reg(logic [medf_pkg::CFG_IDX_W-1:0] idx, logic [medf_pkg::DIM_W-1:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    tracker.set_reg(idx, val);
  endtask

  function logic [medf_pkg::PIX_W-1:0] pick_pixel();
    case (pix_mode)
      0: return 8'($urandom_range(0, 255));
      1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return 8'($urandom_range(100, 103));
    endcase
  endfunction

  // Pixels until the frame wraps, with optional stray flushes (ignored mid-frame).
  task finish_frame(bit noise);
    do begin
      if (noise && $urandom_range(0, 9) == 0) send_word(medf_pkg::CMD_FLUSH, pick_pixel());
      send_word(medf_pkg::CMD_PIXEL, pick_pixel());
    end while (tracker.in_row != 0 || tracker.in_col != 0);
  endtask

  task drain_all();
    while (tracker.pend > 0) send_word(medf_pkg::CMD_FLUSH, pick_pixel());
  endtask

  task new_geometry(logic [medf_pkg::DIM_W-1:0] w, logic [medf_pkg::DIM_W-1:0] h);
    settle();
    write_reg(medf_pkg::REG_WIDTH, w);
    write_reg(medf_pkg::REG_HEIGHT, h);
  endtask

  initial begin
    int stop_at;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Smallest frame, value extremes, flush on an empty pipe and mid-frame.
    new_geometry(12'd6, 12'd6);
    send_word(medf_pkg::CMD_FLUSH, 8'hFF);
    for (int i = 0; i < 36; i++) begin
      if (i == 10) send_word(medf_pkg::CMD_FLUSH, 8'h00);
      send_word(medf_pkg::CMD_PIXEL,
                (i % 3 == 0) ? 8'hFF : ((i % 3 == 1) ? 8'h00 : 8'(i * 7)));
    end
    drain_all();
    send_word(medf_pkg::CMD_FLUSH, 8'h55);

    // New frame before the last one drained: pending words are dropped.
    idle_en = 1'b1;
    new_geometry(12'd7, 12'd8);
    finish_frame(1'b0);
    repeat (3) send_word(medf_pkg::CMD_FLUSH, 8'h00);
    finish_frame(1'b0);
    drain_all();

    // Width shrinks mid-frame once a few rows are in the line stores.
    new_geometry(12'd10, 12'd8);
    repeat (40) send_word(medf_pkg::CMD_PIXEL, pick_pixel());
    settle();
    write_reg(medf_pkg::REG_WIDTH, 12'd7);
    finish_frame(1'b0);
    drain_all();

    // Out-of-range registers clamp: widest row started, then narrowed; short frame.
    idle_en = 1'b0;
    new_geometry(12'd4095, 12'd0);
    repeat (40) send_word(medf_pkg::CMD_PIXEL, pick_pixel());
    settle();
    write_reg(medf_pkg::REG_WIDTH, 12'd8);
    finish_frame(1'b0);
    drain_all();
    new_geometry(12'd0, 12'd0);
    finish_frame(1'b0);
    drain_all();

    // Random frames, mostly small, varied content and idling.
    stop_at = int'(words_sent) + RAND_WORDS;
    while (int'(words_sent) < stop_at) begin
      idle_en = $urandom_range(0, 3) != 0;
      pix_mode = $urandom_range(0, 3) == 0 ? int'($urandom_range(1, 2)) : 0;
      new_geometry(12'($urandom_range(6, 24)), 12'($urandom_range(6, 12)));
      if (!hold_req && $urandom_range(0, 5) == 0) hold_req = 1'b1;
      finish_frame(1'b1);
      if ($urandom_range(0, 4) == 0) begin
        // Partial drain; next frame discards the rest.
        repeat ($urandom_range(0, 6)) send_word(medf_pkg::CMD_FLUSH, pick_pixel());
        finish_frame(1'b1);
      end
      drain_all();
      if ($urandom_range(0, 3) == 0) send_word(medf_pkg::CMD_FLUSH, pick_pixel());
    end

    // Make sure the long receiver hold-off happened with the sender pushing.
    settle();
    idle_en = 1'b0;
    hold_req = 1'b1;
    finish_frame(1'b0);
    drain_all();

    settle();
    if (tracker.errors == 0 && tracker.due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
